[design/gbts_pkg.sv]
// Shared types and constants for the gap buffer text store.
// Used by gbts_ctrl, gbts_dpath and gap_buffer_text_store.
package gbts_pkg;

	localparam int CHAR_W = 8;
	localparam int TXT_W  = 13;

	typedef enum logic [1:0] {
		OP_INSERT    = 2'd0,
		OP_BACKSPACE = 2'd1,
		OP_MOVE      = 2'd2,
		OP_READ      = 2'd3
	} op_t;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic do_insert;
		logic do_backspace;
		logic do_move;
		logic do_read;
		logic shift_rd;
		logic shift_wr;
		logic load_out;
		logic out_mem;
	} cmd_t;

	typedef struct packed {
		logic move_left;
		logic move_right;
		logic out_busy;
	} sts_t;

endpackage

[design/gbts_ctrl.sv]
// Control state machine of the gap buffer text store.
// Depends on gbts_pkg; drives commands into gbts_dpath.
module gbts_ctrl import gbts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  op_t  op,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_MCHK = 4'b0100,
		S_MWR  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign in_stall = (state_q != S_IDLE) || sts.out_busy;
	assign take     = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (op)
						OP_INSERT: begin
							cmd.do_insert = 1'b1;
							cmd.load_out  = 1'b1;
						end
						OP_BACKSPACE: begin
							cmd.do_backspace = 1'b1;
							cmd.load_out     = 1'b1;
						end
						OP_MOVE: begin
							cmd.do_move = 1'b1;
							state_d     = S_MCHK;
						end
						OP_READ: begin
							cmd.do_read = 1'b1;
							state_d     = S_READ;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_READ: begin
				cmd.load_out = 1'b1;
				cmd.out_mem  = 1'b1;
				state_d      = S_IDLE;
			end
			S_MCHK: begin
				if (sts.move_left || sts.move_right) begin
					cmd.shift_rd = 1'b1;
					state_d      = S_MWR;
				end else begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_MWR: begin
				cmd.shift_wr = 1'b1;
				state_d      = S_MCHK;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_rd |=> cmd.shift_wr)
		else $error("shift write did not follow shift read");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !take)
		else $error("request taken while busy");
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_read |=> cmd.load_out)
		else $error("read result not loaded");
`endif

endmodule

[design/gbts_dpath.sv]
// Datapath of the gap buffer text store: gap registers, character memory,
// result register. Depends on gbts_pkg; commanded by gbts_ctrl.
module gbts_dpath import gbts_pkg::*; #(
	parameter int CAPACITY = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [CHAR_W-1:0] char_in,
	input  logic [TXT_W-1:0]  position,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic [CHAR_W-1:0] char_out,
	output logic [TXT_W-1:0]  text_length,
	output logic [TXT_W-1:0]  cursor,
	output logic              modified
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int XW = (CW > TXT_W) ? CW : TXT_W;

	logic [CHAR_W-1:0] mem [CAPACITY];
	logic [CHAR_W-1:0] rdata_q;

	logic [CW-1:0] gs_q, gl_q, len_q, target_q;
	logic [CW-1:0] gs_d, gl_d, len_d;
	logic          mod_q, mod_d;
	logic          rd_hit_q;
	logic          out_valid_q;

	logic [XW-1:0] pos_x;
	logic          hit, full, ins_ok;
	logic [CW-1:0] gs_m1, gs_p_gl, gs_m1_gl, rd_idx;
	logic          we, re;
	logic [AW-1:0] wa, ra;
	logic [CHAR_W-1:0] wd;

	assign pos_x    = XW'(position);
	assign hit      = pos_x < XW'(len_q);
	assign full     = (gl_q == '0);
	assign ins_ok   = cmd.do_insert && !full;
	assign gs_m1    = gs_q - CW'(1);
	assign gs_p_gl  = gs_q + gl_q;
	assign gs_m1_gl = gs_m1 + gl_q;
	assign rd_idx   = (pos_x < XW'(gs_q)) ? CW'(position) : CW'(position) + gl_q;

	assign sts.move_left  = gs_q > target_q;
	assign sts.move_right = gs_q < target_q;
	assign sts.out_busy   = out_valid_q && out_stall;

	always_comb begin
		gs_d  = gs_q;
		gl_d  = gl_q;
		len_d = len_q;
		mod_d = mod_q;
		if (ins_ok) begin
			gs_d  = gs_q + CW'(1);
			gl_d  = gl_q - CW'(1);
			len_d = len_q + CW'(1);
			mod_d = 1'b1;
		end
		if (cmd.do_backspace && gs_q != '0) begin
			gs_d  = gs_m1;
			gl_d  = gl_q + CW'(1);
			len_d = len_q - CW'(1);
			mod_d = 1'b1;
		end
		if (cmd.shift_wr) begin
			gs_d = sts.move_left ? gs_m1 : gs_q + CW'(1);
		end
	end

	assign we = ins_ok || cmd.shift_wr;
	assign wd = cmd.do_insert ? char_in : rdata_q;
	assign re = (cmd.do_read && hit) || cmd.shift_rd;

	always_comb begin
		if (cmd.do_insert) begin
			wa = gs_q[AW-1:0];
		end else if (sts.move_left) begin
			wa = gs_m1_gl[AW-1:0];
		end else begin
			wa = gs_q[AW-1:0];
		end
		if (cmd.do_read) begin
			ra = rd_idx[AW-1:0];
		end else if (sts.move_left) begin
			ra = gs_m1[AW-1:0];
		end else begin
			ra = gs_p_gl[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_q <= mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_move) begin
			target_q <= (pos_x > XW'(len_q)) ? len_q : CW'(position);
		end
		if (cmd.do_read) begin
			rd_hit_q <= hit;
		end
		if (cmd.load_out) begin
			status      <= (cmd.do_insert && full) ? ST_FULL : ST_OK;
			char_out    <= (cmd.out_mem && rd_hit_q) ? rdata_q : '0;
			text_length <= TXT_W'(len_d);
			cursor      <= TXT_W'(gs_d);
			modified    <= mod_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q        <= '0;
			gl_q        <= CW'(CAPACITY);
			len_q       <= '0;
			mod_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			gs_q  <= gs_d;
			gl_q  <= gl_d;
			len_q <= len_d;
			mod_q <= mod_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_gap_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q + gl_q) == CW'(CAPACITY))
		else $error("text length and gap length disagree");
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		gs_q <= len_q)
		else $error("cursor beyond text");
	a_mod_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mod_q |=> mod_q)
		else $error("modified flag cleared");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.out_busy)
		else $error("result loaded over a waiting result");
`endif

endmodule

[design/gap_buffer_text_store.sv]
// Gap buffer text store top level. Insert and backspace load the result register directly;
// read loads it in S_READ; move shifts each char with one memory read then one write.
// Insert and backspace sustain one request a cycle while results are taken.
// Reset (arst_n, async) empties the text and clears modified; the character memory
// is left undefined and needs no clearing pass.
// Depends on gbts_pkg, gbts_ctrl and gbts_dpath.
module gap_buffer_text_store import gbts_pkg::*; #(
	parameter int CAPACITY = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [CHAR_W-1:0] char_in,
	input  logic [TXT_W-1:0]  position,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic [CHAR_W-1:0] char_out,
	output logic [TXT_W-1:0]  text_length,
	output logic [TXT_W-1:0]  cursor,
	output logic              modified
);

	cmd_t cmd;
	sts_t sts;

	gbts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op_t'(opcode)),
		.sts      (sts),
		.cmd      (cmd)
	);

	gbts_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.char_in     (char_in),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.char_out    (char_out),
		.text_length (text_length),
		.cursor      (cursor),
		.modified    (modified)
	);

endmodule
